/* rtl/twsac_pkg.sv */
// ----------------------------------------------------------------------------
// twsac_pkg: shared definitions for the two-way set-associative cache
// Geometry constants, derived widths, the controller state type and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package twsac_pkg;

  // Cache and backing memory geometry.
  localparam int SET_COUNT     = 16384;
  localparam int LINE_BYTES    = 4;
  localparam int BACKING_BYTES = 65536;
  localparam int TAG_WIDTH     = 16;

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;

  // Derived widths.
  localparam int OFFSET_W = $clog2(LINE_BYTES);
  localparam int SET_W    = $clog2(SET_COUNT);
  localparam int LINE_W   = SET_W + OFFSET_W;
  localparam int BACK_W   = $clog2(BACKING_BYTES);
  localparam int TAG_LSB  = OFFSET_W + SET_W;
  localparam int SUM_W    = (LINE_W > BACK_W) ? LINE_W : BACK_W;
  localparam int LINE_STORE = SET_COUNT * LINE_BYTES;

  // Request command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPARE,
    ST_FILL,
    ST_DRAIN,
    ST_RESPOND
  } state_t;

  // Per-set bookkeeping: valid bits of both ways and the replacement victim.
  typedef struct packed {
    logic valid0;
    logic valid1;
    logic victim1;
  } meta_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic resolve;
    logic fill;
    logic respond;
    logic clear;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic fill_last;
    logic clear_done;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* rtl/twsac_ctrl.sv */
// ----------------------------------------------------------------------------
// twsac_ctrl: cache controller state machine
// Sequences the set clearing pass, lookup, line fill and response, and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module twsac_ctrl
  import twsac_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  input  wire logic         cmd,
  input  wire ctrl_status_t status,
  output logic              req_stall,
  output ctrl_cmd_t         ctrl
);

  state_t state;
  state_t state_next;

  // State register; the clearing pass runs first after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid && (cmd == CMD_READ)) state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = status.hit ? ST_RESPOND : ST_FILL;
      end
      ST_FILL: begin
        if (status.fill_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    req_stall    = (state != ST_IDLE);
    ctrl         = '0;
    ctrl.capture = (state == ST_IDLE) && req_valid && (cmd == CMD_READ);
    ctrl.load    = (state == ST_IDLE) && req_valid && (cmd == CMD_LOAD);
    ctrl.resolve = (state == ST_COMPARE);
    ctrl.fill    = (state == ST_FILL);
    ctrl.respond = (state == ST_RESPOND) && status.out_free;
    ctrl.clear   = (state == ST_CLEAR);
  end

endmodule

`default_nettype wire

/* rtl/twsac_dp.sv */
// ----------------------------------------------------------------------------
// twsac_dp: cache datapath
// Holds the tag, set bookkeeping, line and backing memories, the tag
// compare, the line fill pipeline, the counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module twsac_dp
  import twsac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_cmd_t         ctrl,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [DATA_W-1:0] write_data,
  input  wire logic              rsp_stall,
  output ctrl_status_t           status,
  output logic                   rsp_valid,
  output logic [DATA_W-1:0]      read_data,
  output logic                   hit,
  output logic                   way_used,
  output logic [CNT_W-1:0]       hit_total,
  output logic [CNT_W-1:0]       miss_total
);

  // Storage.
  logic [TAG_WIDTH-1:0] tag0_mem  [SET_COUNT];
  logic [TAG_WIDTH-1:0] tag1_mem  [SET_COUNT];
  meta_t                meta_mem  [SET_COUNT];
  logic [DATA_W-1:0]    line0_mem [LINE_STORE];
  logic [DATA_W-1:0]    line1_mem [LINE_STORE];
  logic [DATA_W-1:0]    back_mem  [BACKING_BYTES];

  // Registers.
  logic [ADDR_W-1:0]    addr_q;
  logic [TAG_WIDTH-1:0] tag0_rd;
  logic [TAG_WIDTH-1:0] tag1_rd;
  meta_t                meta_rd;
  logic [DATA_W-1:0]    line0_rd;
  logic [DATA_W-1:0]    line1_rd;
  logic [DATA_W-1:0]    back_rd;
  logic                 way_q;
  logic                 hit_q;
  logic [DATA_W-1:0]    res_data;
  logic [CNT_W-1:0]     hit_cnt;
  logic [CNT_W-1:0]     miss_cnt;
  logic [SET_W-1:0]     clr_cnt;
  logic [OFFSET_W-1:0]  fill_cnt;
  logic                 fill_wr;
  logic [OFFSET_W-1:0]  fill_wr_idx;

  // Combinational signals.
  logic [ADDR_W-1:0]    rd_addr;
  logic [SET_W-1:0]     rd_set;
  logic [OFFSET_W-1:0]  rd_off;
  logic [SET_W-1:0]     set_q;
  logic [OFFSET_W-1:0]  off_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic                 match0;
  logic                 match1;
  logic                 hit_now;
  logic                 way_sel;
  meta_t                meta_new;
  logic                 meta_we;
  logic [SET_W-1:0]     meta_wa;
  meta_t                meta_wd;
  logic [SUM_W-1:0]     fill_sum;
  logic [BACK_W-1:0]    back_ra;
  logic [LINE_W-1:0]    line_wa;

  // Address split. Lookups read at the incoming address on the accepting cycle.
  assign rd_addr = ctrl.capture ? address : addr_q;
  assign rd_set  = rd_addr[TAG_LSB-1:OFFSET_W];
  assign rd_off  = rd_addr[OFFSET_W-1:0];
  assign set_q   = addr_q[TAG_LSB-1:OFFSET_W];
  assign off_q   = addr_q[OFFSET_W-1:0];
  assign tag_q   = TAG_WIDTH'(addr_q >> TAG_LSB);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      addr_q <= address;
    end
  end

  // Registered reads of tags, bookkeeping and line bytes.
  always_ff @(posedge clk) begin
    tag0_rd  <= tag0_mem[rd_set];
    tag1_rd  <= tag1_mem[rd_set];
    meta_rd  <= meta_mem[rd_set];
    line0_rd <= line0_mem[{rd_set, rd_off}];
    line1_rd <= line1_mem[{rd_set, rd_off}];
  end

  // Tag compare; way 0 wins when both match. A miss replaces the victim way.
  assign match0  = meta_rd.valid0 && (tag0_rd == tag_q);
  assign match1  = meta_rd.valid1 && (tag1_rd == tag_q);
  assign hit_now = match0 || match1;
  assign way_sel = hit_now ? !match0 : meta_rd.victim1;

  always_comb begin
    meta_new.valid0  = meta_rd.valid0 || (!hit_now && !way_sel);
    meta_new.valid1  = meta_rd.valid1 || (!hit_now && way_sel);
    meta_new.victim1 = !way_sel;
  end

  // Bookkeeping write port: the clearing pass or the update after a lookup.
  assign meta_we = ctrl.clear || ctrl.resolve;
  assign meta_wa = ctrl.clear ? clr_cnt : set_q;
  always_comb begin
    if (ctrl.clear) begin
      meta_wd = '{valid0: 1'b0, valid1: 1'b0, victim1: 1'b1};
    end else begin
      meta_wd = meta_new;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
  end

  // Tag write on a miss.
  always_ff @(posedge clk) begin
    if (ctrl.resolve && !hit_now && !way_sel) begin
      tag0_mem[set_q] <= tag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.resolve && !hit_now && way_sel) begin
      tag1_mem[set_q] <= tag_q;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctrl.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Line fill: read backing bytes of the line in order, write each one from the registered backing read.
  assign fill_sum = SUM_W'({set_q, fill_cnt});
  assign back_ra  = BACK_W'(fill_sum);
  assign line_wa  = {set_q, fill_wr_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      fill_wr  <= 1'b0;
    end else begin
      fill_wr <= ctrl.fill;
      if (ctrl.fill) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_wr_idx <= fill_cnt;
  end

  // Backing memory: loads write at the accepting cycle, fills read it.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      back_mem[address[BACK_W-1:0]] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    back_rd <= back_mem[back_ra];
  end

  always_ff @(posedge clk) begin
    if (fill_wr && !way_q) begin
      line0_mem[line_wa] <= back_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_wr && way_q) begin
      line1_mem[line_wa] <= back_rd;
    end
  end

  // Result of the lookup, and the requested byte as it passes during a fill.
  always_ff @(posedge clk) begin
    if (ctrl.resolve) begin
      way_q <= way_sel;
      hit_q <= hit_now;
      if (hit_now) begin
        res_data <= match0 ? line0_rd : line1_rd;
      end
    end else if (fill_wr && (fill_wr_idx == off_q)) begin
      res_data <= back_rd;
    end
  end

  // Saturating hit and miss counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else if (ctrl.resolve) begin
      if (hit_now) begin
        if (hit_cnt != '1) hit_cnt <= hit_cnt + 1'b1;
      end else begin
        if (miss_cnt != '1) miss_cnt <= miss_cnt + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.respond) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      read_data  <= res_data;
      hit        <= hit_q;
      way_used   <= way_q;
      hit_total  <= hit_cnt;
      miss_total <= miss_cnt;
    end
  end

  // Status to the controller.
  always_comb begin
    status.hit        = hit_now;
    status.fill_last  = (fill_cnt == OFFSET_W'(LINE_BYTES - 1));
    status.clear_done = (clr_cnt == SET_W'(SET_COUNT - 1));
    status.out_free   = !rsp_valid || !rsp_stall;
  end

  // The hit counter never goes backward outside reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hit_cnt >= $past(hit_cnt)))
    else $error("hit counter decreased");

  // The miss counter never goes backward outside reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (miss_cnt >= $past(miss_cnt)))
    else $error("miss counter decreased");

  // Every lookup moves one counter; the check is waived once either counter is full.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.resolve |=> (hit_cnt != $past(hit_cnt)) || (miss_cnt != $past(miss_cnt))
                     || ($past(hit_cnt) == '1) || ($past(miss_cnt) == '1))
    else $error("lookup did not update a counter");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.respond |-> (!rsp_valid || !rsp_stall))
    else $error("result overwrote a waiting transaction");

endmodule

`default_nettype wire

/* rtl/two_way_set_assoc_cache.sv */
// ----------------------------------------------------------------------------
// two_way_set_assoc_cache: read-only two-way set-associative cache
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) writes one byte of backing memory and keeps the
// controller idle, so loads may stream back to back. A read transaction (cmd 1)
// looks the address up in both ways of its set and returns one result: a hit
// passes from acceptance to the result register through accept with the memory
// read, tag compare and response; a miss adds the line fill and drain, since the
// line fill reads the four backing bytes one per cycle through the single backing
// memory port and writes each into the victim way from the registered read. After
// reset the block clears the per-set valid and replacement bits, one set per cycle,
// for all 16384 sets while req_stall is high. A finished result waits in the
// output register while the next transaction is accepted.
`default_nettype none

module two_way_set_assoc_cache
  import twsac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic              cmd,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [DATA_W-1:0] write_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [DATA_W-1:0]      read_data,
  output logic                   hit,
  output logic                   way_used,
  output logic [CNT_W-1:0]       hit_total,
  output logic [CNT_W-1:0]       miss_total
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  // Controller.
  twsac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cmd       (cmd),
    .status    (status),
    .req_stall (req_stall),
    .ctrl      (ctrl)
  );

  // Datapath.
  twsac_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .address    (address),
    .write_data (write_data),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .rsp_valid  (rsp_valid),
    .read_data  (read_data),
    .hit        (hit),
    .way_used   (way_used),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-way set-associative read cache
// Loads backing memory lines, then issues directed and random reads that hit,
// miss and evict. A shadow copy of the cache predicts every read result, and
// each returned transaction is compared field by field with that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import twsac_pkg::*;
();

  // One predicted read result.
  typedef struct {
    logic [DATA_W-1:0] data;
    logic              hit;
    logic              way;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
  } read_result_t;

  // Shadow copy of the cache state plus the queue of pending read results.
  class cache_shadow;
    logic [TAG_WIDTH-1:0] tag0    [SET_COUNT];
    logic [TAG_WIDTH-1:0] tag1    [SET_COUNT];
    bit                   valid0  [SET_COUNT];
    bit                   valid1  [SET_COUNT];
    bit                   victim1 [SET_COUNT];
    logic [DATA_W-1:0]    line0   [LINE_STORE];
    logic [DATA_W-1:0]    line1   [LINE_STORE];
    logic [DATA_W-1:0]    backing [BACKING_BYTES];
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    read_result_t         expected_reads[$];
    int                   errors;

    function new();
      foreach (victim1[s]) begin
        valid0[s]  = 1'b0;
        valid1[s]  = 1'b0;
        victim1[s] = 1'b1;
      end
      hit_count  = '0;
      miss_count = '0;
      errors     = 0;
    endfunction

    // Apply one accepted transaction and queue its result if it is a read.
    function void note_request(logic c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
      int unsigned          set_idx;
      int unsigned          off;
      int unsigned          base;
      logic [TAG_WIDTH-1:0] tag;
      read_result_t         r;
      if (c == CMD_LOAD) begin
        backing[a % BACKING_BYTES] = d;
        return;
      end
      off     = a % LINE_BYTES;
      set_idx = (a / LINE_BYTES) % SET_COUNT;
      tag     = TAG_WIDTH'(a / (LINE_BYTES * SET_COUNT));
      base    = set_idx * LINE_BYTES;
      if (valid0[set_idx] && tag0[set_idx] == tag) begin
        r.hit            = 1'b1;
        r.way            = 1'b0;
        r.data           = line0[base + off];
        victim1[set_idx] = 1'b1;
        if (hit_count != '1) hit_count++;
      end else if (valid1[set_idx] && tag1[set_idx] == tag) begin
        r.hit            = 1'b1;
        r.way            = 1'b1;
        r.data           = line1[base + off];
        victim1[set_idx] = 1'b0;
        if (hit_count != '1) hit_count++;
      end else begin
        // Miss: the fill address comes from the set alone, never the tag.
        r.hit = 1'b0;
        r.way = victim1[set_idx];
        for (int i = 0; i < LINE_BYTES; i++) begin
          if (victim1[set_idx]) line1[base + i] = backing[(base + i) % BACKING_BYTES];
          else                  line0[base + i] = backing[(base + i) % BACKING_BYTES];
        end
        if (victim1[set_idx]) begin
          tag1[set_idx]   = tag;
          valid1[set_idx] = 1'b1;
          r.data          = line1[base + off];
        end else begin
          tag0[set_idx]   = tag;
          valid0[set_idx] = 1'b1;
          r.data          = line0[base + off];
        end
        victim1[set_idx] = ~victim1[set_idx];
        if (miss_count != '1) miss_count++;
      end
      r.hits   = hit_count;
      r.misses = miss_count;
      expected_reads.push_back(r);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Check one returned read transaction against the oldest prediction.
    function void check_read(logic [DATA_W-1:0] data, logic h, logic w,
                             logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses);
      read_result_t r;
      if (expected_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected read result, expected none actual data %0h", $time, data);
        return;
      end
      r = expected_reads.pop_front();
      compare_field("read_data", CNT_W'(r.data), CNT_W'(data));
      compare_field("hit", CNT_W'(r.hit), CNT_W'(h));
      compare_field("way_used", CNT_W'(r.way), CNT_W'(w));
      compare_field("hit_total", r.hits, hits);
      compare_field("miss_total", r.misses, misses);
    endfunction
  endclass

  logic              clk;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  logic              cmd        = CMD_LOAD;
  logic [ADDR_W-1:0] address    = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              rsp_stall  = 1'b0;
  wire               req_stall;
  wire               rsp_valid;
  wire [DATA_W-1:0]  read_data;
  wire               hit;
  wire               way_used;
  wire [CNT_W-1:0]   hit_total;
  wire [CNT_W-1:0]   miss_total;

  cache_shadow          shadow = new();
  bit                   send_idle_on = 1'b1;
  bit                   recv_idle_on = 1'b1;
  int                   stall_left   = 0;
  int unsigned          ready_sets[$];
  logic [TAG_WIDTH-1:0] tag_pool[4];

  two_way_set_assoc_cache DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .address    (address),
    .write_data (write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data),
    .hit        (hit),
    .way_used   (way_used),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one transaction and hold it until accepted, then maybe idle.
  task automatic issue_request(logic c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    req_valid  <= 1'b1;
    cmd        <= c;
    address    <= a;
    write_data <= d;
    do begin
      @(posedge clk);
    end while (req_stall !== 1'b0);
    shadow.note_request(c, a, d);
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Load a whole backing line for one set; upper address bits are don't-care.
  task automatic load_line(int unsigned set_idx);
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < LINE_BYTES; i++) begin
      a = $urandom;
      a[TAG_LSB-1:0] = TAG_LSB'((set_idx * LINE_BYTES + i) % BACKING_BYTES);
      issue_request(CMD_LOAD, a, DATA_W'($urandom_range(0, 255)));
    end
    ready_sets.push_back(set_idx);
  endtask

  task automatic read_at(logic [TAG_WIDTH-1:0] tag, int unsigned set_idx,
                         int unsigned off);
    logic [SET_W-1:0]    s;
    logic [OFFSET_W-1:0] o;
    s = SET_W'(set_idx);
    o = OFFSET_W'(off);
    issue_request(CMD_READ, {tag, s, o}, DATA_W'($urandom_range(0, 255)));
  endtask

  // Stop sending until every pending read result has come back.
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (shadow.expected_reads.size() != 0);
  endtask

  // Random mix: whole line loads, stray loads and reads of loaded lines.
  task automatic random_traffic(int n_items);
    int          count;
    int unsigned pick;
    int unsigned set_idx;
    logic [TAG_WIDTH-1:0] tag;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        set_idx = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                       : $urandom_range(0, SET_COUNT - 1);
        load_line(set_idx);
        count += LINE_BYTES;
      end else if (pick < 22) begin
        issue_request(CMD_LOAD, $urandom, DATA_W'($urandom_range(0, 255)));
        count++;
      end else begin
        set_idx = ready_sets[$urandom_range(0, ready_sets.size() - 1)];
        tag = ($urandom_range(0, 9) < 8) ? tag_pool[$urandom_range(0, 3)]
                                         : TAG_WIDTH'($urandom);
        read_at(tag, set_idx, $urandom_range(0, LINE_BYTES - 1));
        count++;
      end
    end
  endtask

  // Result side: check accepted transactions and stall in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        shadow.check_read(read_data, hit, way_used, hit_total, miss_total);
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        rsp_stall  <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Main sequence: reset, directed cases, random phases, drain and report.
  initial begin
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_WIDTH'($urandom);
    tag_pool[3] = TAG_WIDTH'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Backing lines for the lowest and highest sets, with extreme bytes.
    issue_request(CMD_LOAD, 32'h0000_0000, 8'h00);
    issue_request(CMD_LOAD, 32'hFFFF_0001, 8'hFF);
    issue_request(CMD_LOAD, 32'h1234_0002, 8'hA5);
    issue_request(CMD_LOAD, 32'h0000_0003, 8'h5A);
    issue_request(CMD_LOAD, 32'h0000_FFFC, 8'h11);
    issue_request(CMD_LOAD, 32'hFFFF_FFFD, 8'h80);
    issue_request(CMD_LOAD, 32'h0000_FFFE, 8'h7F);
    issue_request(CMD_LOAD, 32'hAAAA_FFFF, 8'hC3);
    ready_sets.push_back(0);
    ready_sets.push_back(SET_COUNT - 1);

    // Set 0: fill way 1 first, then alternate victims through hits and misses.
    issue_request(CMD_READ, 32'h0000_0000, 8'hFF);
    issue_request(CMD_READ, 32'h0000_0001, 8'h00);
    issue_request(CMD_READ, 32'hFFFF_0002, 8'h00);
    issue_request(CMD_READ, 32'h0000_0003, 8'h00);
    issue_request(CMD_READ, 32'hABCD_0000, 8'h00);
    issue_request(CMD_READ, 32'hFFFF_0003, 8'h00);

    // Top set with all-ones and zero tags; the tag never selects backing bytes.
    issue_request(CMD_READ, 32'hFFFF_FFFF, 8'h00);
    issue_request(CMD_READ, 32'h0000_FFFE, 8'h00);
    issue_request(CMD_READ, 32'hFFFF_FFFC, 8'h00);

    // Stale line: rewrite backing under a cached line, then refill another way.
    issue_request(CMD_LOAD, 32'h0000_FFFF, 8'h3C);
    issue_request(CMD_READ, 32'hFFFF_FFFF, 8'h00);
    issue_request(CMD_READ, 32'h8000_FFFD, 8'h00);
    issue_request(CMD_READ, 32'h8000_FFFF, 8'h00);
    issue_request(CMD_READ, 32'hFFFF_FFFF, 8'h00);

    // Random phases with different idling on each side.
    random_traffic(310);
    wait_results_drained();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b0;
    random_traffic(310);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    random_traffic(310);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    random_traffic(310);
    wait_results_drained();
    random_traffic(310);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    random_traffic(310);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (shadow.errors == 0)
      $display("** two_way_set_assoc_cache: PASSED **");
    else
      $display("** two_way_set_assoc_cache: FAILED **");
    $finish;
  end

  // Watchdog: covers the clearing pass after reset and a slow correct run.
  initial begin
    #3000000;
    $display("** two_way_set_assoc_cache: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
